FILE: src/sgc_pkg.sv
package sgc_pkg;

  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 8;
  localparam int CORR_W     = 4;
  localparam int WIN_CFG_W  = 11;
  localparam int THR_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]    GAIN_RESET = 8'd200;
  localparam logic [WIN_CFG_W-1:0] WIN_RESET  = 11'd256;
  localparam logic [THR_W-1:0]     THR_RESET  = 12'd4000;

  // Gain steps for the three saturation bands and the quiet case
  localparam logic signed [CORR_W-1:0] CORR_HEAVY  = -4'sd5;
  localparam logic signed [CORR_W-1:0] CORR_MEDIUM = -4'sd2;
  localparam logic signed [CORR_W-1:0] CORR_LIGHT  = -4'sd1;
  localparam logic signed [CORR_W-1:0] CORR_NONE   = 4'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH      = 2'd0,
    CFG_SATURATION_THRESH  = 2'd1
  } sgc_cfg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch3;
  } sgc_in_t;

  typedef struct packed {
    logic                      write_valid;
    logic [CH_W-1:0]           channel;
    logic [GAIN_W-1:0]         new_gain;
    logic signed [CORR_W-1:0]  correction;
    logic                      status;
    logic                      last;
  } sgc_out_t;

endpackage

FILE: src/saturation_gain_calibrator.sv
// Path: a frame that closes a window reaches out_* as its first result transaction
//   through the snapshot, pending buffer and result registers.
// Throughput: one frame per cycle inside a window; a window-closing frame waits
//   for a free snapshot slot and for the earlier results to drain.
// Reset: counts and frame counter clear, gains 200, window 256, threshold 4000.
module saturation_gain_calibrator import sgc_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sgc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sgc_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Counts never exceed the window, so this is wide enough for both.
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int PROD_W = CNT_W + 5;
  localparam int WIN_RST_INT = (int'(WIN_RESET) > MAX_WINDOW) ? MAX_WINDOW
                                                              : int'(WIN_RESET);
  localparam logic [CNT_W-1:0]  WIN_RST     = CNT_W'(WIN_RST_INT);
  localparam logic [PROD_W-1:0] THR_HI_RST  = PROD_W'(WIN_RST_INT * 7);
  localparam logic [PROD_W-1:0] THR_MID_RST = PROD_W'(WIN_RST_INT * 4);
  localparam logic [PROD_W-1:0] THR_LO_RST  = PROD_W'(WIN_RST_INT);

  logic [WIN_CFG_W-1:0] cfg_win_q;
  logic [THR_W-1:0]     cfg_thr_q;
  logic                 cfg_write;

  // Effective window and band limits, re-derived every cycle from config.
  logic [CNT_W-1:0]     win_q, win_d;
  logic [PROD_W-1:0]    thr_hi_q, thr_hi_d;
  logic [PROD_W-1:0]    thr_mid_q, thr_mid_d;
  logic [PROD_W-1:0]    thr_lo_q, thr_lo_d;

  logic                         pend_busy;
  logic                         snap_valid;
  logic [NUM_CH-1:0][CNT_W-1:0] snap_cnt;

  // Config writes are always taken; unknown indexes drop silently.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_win_q <= WIN_RESET;
      cfg_thr_q <= THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LENGTH:     cfg_win_q <= cfg_data_i[WIN_CFG_W-1:0];
        CFG_SATURATION_THRESH: cfg_thr_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the window to [1, MAX_WINDOW]; a zero length acts as one frame.
  always_comb begin
    if (cfg_win_q == '0) begin
      win_d = CNT_W'(1);
    end else if (32'(cfg_win_q) > 32'(MAX_WINDOW)) begin
      win_d = CNT_W'(MAX_WINDOW);
    end else begin
      win_d = CNT_W'(cfg_win_q);
    end
    thr_hi_d  = PROD_W'(win_d) * PROD_W'(7);
    thr_mid_d = PROD_W'(win_d) * PROD_W'(4);
    thr_lo_d  = PROD_W'(win_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= WIN_RST;
      thr_hi_q  <= THR_HI_RST;
      thr_mid_q <= THR_MID_RST;
      thr_lo_q  <= THR_LO_RST;
    end else begin
      win_q     <= win_d;
      thr_hi_q  <= thr_hi_d;
      thr_mid_q <= thr_mid_d;
      thr_lo_q  <= thr_lo_d;
    end
  end

  // Frame register, per-channel saturation counts and the window snapshot.
  sgc_counter #(
    .CNT_W (CNT_W)
  ) u_counter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .thr_i        (cfg_thr_q),
    .win_i        (win_q),
    .pend_busy_i  (pend_busy),
    .snap_valid_o (snap_valid),
    .snap_cnt_o   (snap_cnt)
  );

  // Band decision, gain update, one result transaction per cycle when not stalled.
  sgc_judge #(
    .CNT_W (CNT_W)
  ) u_judge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_cnt_i   (snap_cnt),
    .thr_hi_i     (thr_hi_q),
    .thr_mid_i    (thr_mid_q),
    .thr_lo_i     (thr_lo_q),
    .pend_busy_o  (pend_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: src/sgc_counter.sv
module sgc_counter import sgc_pkg::*; #(
  parameter int CNT_W = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sgc_in_t                        in_data_i,
  input  logic [THR_W-1:0]               thr_i,
  input  logic [CNT_W-1:0]               win_i,
  input  logic                           pend_busy_i,
  output logic                           snap_valid_o,
  output logic [NUM_CH-1:0][CNT_W-1:0]   snap_cnt_o
);

  logic                          s1_valid_q, s1_valid_d;
  sgc_in_t                       s1_data_q;
  logic [NUM_CH-1:0][CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [CNT_W-1:0]              frame_q, frame_d;
  logic                          snap_valid_q, snap_valid_d;
  logic [NUM_CH-1:0][CNT_W-1:0]  snap_cnt_q;
  logic [NUM_CH-1:0][SAMPLE_W-1:0] samples;
  logic [CNT_W:0]                frame_next;
  logic                          win_end, free, fire, accept;

  assign samples = {s1_data_q.sample_ch3, s1_data_q.sample_ch2,
                    s1_data_q.sample_ch1, s1_data_q.sample_ch0};

  assign frame_next = {1'b0, frame_q} + {{CNT_W{1'b0}}, 1'b1};
  assign win_end    = frame_next >= {1'b0, win_i};
  // a window end needs both the evaluation slot and the result buffer empty
  assign free       = !snap_valid_q && !pend_busy_i;
  assign fire       = s1_valid_q && (!win_end || free);
  assign in_stall_o = s1_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      cnt_inc[i] = cnt_q[i] + {{(CNT_W-1){1'b0}}, (samples[i] > thr_i)};
    end
    s1_valid_d   = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
    cnt_d        = cnt_q;
    frame_d      = frame_q;
    snap_valid_d = 1'b0;
    if (fire) begin
      if (win_end) begin
        cnt_d        = '0;
        frame_d      = '0;
        snap_valid_d = 1'b1;
      end else begin
        cnt_d   = cnt_inc;
        frame_d = frame_next[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      cnt_q        <= '0;
      frame_q      <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      cnt_q        <= cnt_d;
      frame_q      <= frame_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= in_data_i;
    end
    if (fire && win_end) begin
      snap_cnt_q <= cnt_inc;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_cnt_o   = snap_cnt_q;

`ifndef SYNTHESIS
  a_snap_into_empty_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q |-> !pend_busy_i)
    else $error("window snapshot taken while result buffer busy");

  a_snap_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q |=> !snap_valid_q)
    else $error("back-to-back window snapshots");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && win_end && !free) |=> (s1_valid_q && $stable(s1_data_q)
                                          && $stable(frame_q)))
    else $error("window-end frame lost while downstream busy");
`endif

endmodule

FILE: src/sgc_judge.sv
module sgc_judge import sgc_pkg::*; #(
  parameter int CNT_W = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           snap_valid_i,
  input  logic [NUM_CH-1:0][CNT_W-1:0]   snap_cnt_i,
  input  logic [CNT_W+4:0]               thr_hi_i,
  input  logic [CNT_W+4:0]               thr_mid_i,
  input  logic [CNT_W+4:0]               thr_lo_i,
  output logic                           pend_busy_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sgc_out_t                       out_data_o
);

  localparam int PROD_W = CNT_W + 5;

  logic [NUM_CH-1:0][GAIN_W-1:0]  gain_q, gain_d;
  logic [NUM_CH-1:0][GAIN_W-1:0]  gain_upd;
  logic [NUM_CH-1:0][CORR_W-1:0]  corr;
  logic [NUM_CH-1:0]              corr_mask;
  logic [NUM_CH-1:0][PROD_W-1:0]  cnt_x10, cnt_x20;

  logic                           pend_busy_q, pend_busy_d;
  logic [NUM_CH-1:0]              pend_mask_q, pend_mask_d;
  logic [NUM_CH-1:0][GAIN_W-1:0]  pend_gain_q;
  logic [NUM_CH-1:0][CORR_W-1:0]  pend_corr_q;

  logic                           out_valid_q, out_valid_d;
  sgc_out_t                       out_q, out_d;
  logic                           out_load;
  logic [CH_W-1:0]                sel;
  logic [NUM_CH-1:0]              mask_rest;

  // Bands: count > floor(7w/10) <=> 10c > 7w, likewise for 4w, and
  // count > floor(5w/100) <=> 20c > w.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      cnt_x10[i] = PROD_W'(snap_cnt_i[i]) * PROD_W'(10);
      cnt_x20[i] = PROD_W'(snap_cnt_i[i]) * PROD_W'(20);
      if (cnt_x10[i] > thr_hi_i) begin
        corr[i] = CORR_HEAVY;
      end else if (cnt_x10[i] > thr_mid_i) begin
        corr[i] = CORR_MEDIUM;
      end else if (cnt_x20[i] > thr_lo_i) begin
        corr[i] = CORR_LIGHT;
      end else begin
        corr[i] = CORR_NONE;
      end
      corr_mask[i] = (corr[i] != CORR_NONE);
      gain_upd[i]  = gain_q[i] + {{(GAIN_W-CORR_W){corr[i][CORR_W-1]}}, corr[i]};
      gain_d[i]    = (snap_valid_i && corr_mask[i]) ? gain_upd[i] : gain_q[i];
    end
  end

  always_comb begin
    sel = '0;
    for (int i = NUM_CH - 1; i >= 0; i--) begin
      if (pend_mask_q[i]) begin
        sel = CH_W'(i);
      end
    end
    mask_rest      = pend_mask_q;
    mask_rest[sel] = 1'b0;
  end

  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    pend_busy_d = pend_busy_q;
    pend_mask_d = pend_mask_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = pend_busy_q;
      if (pend_busy_q) begin
        if (pend_mask_q == '0) begin
          out_d = '{write_valid: 1'b0, channel: '0, new_gain: '0,
                    correction: CORR_NONE, status: 1'b0, last: 1'b1};
        end else begin
          out_d = '{write_valid: 1'b1, channel: sel, new_gain: pend_gain_q[sel],
                    correction: pend_corr_q[sel], status: 1'b1,
                    last: (mask_rest == '0)};
        end
        pend_mask_d = mask_rest;
        pend_busy_d = (mask_rest != '0);
      end
    end
    if (snap_valid_i) begin
      pend_busy_d = 1'b1;
      pend_mask_d = corr_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= {NUM_CH{GAIN_RESET}};
      pend_busy_q <= 1'b0;
      pend_mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      gain_q      <= gain_d;
      pend_busy_q <= pend_busy_d;
      pend_mask_q <= pend_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (snap_valid_i) begin
      pend_gain_q <= gain_upd;
      pend_corr_q <= corr;
    end
  end

  assign pend_busy_o = pend_busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_mask_implies_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_mask_q != '0) |-> pend_busy_q)
    else $error("pending corrections without busy flag");

  a_write_is_corrected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.write_valid) |-> (out_q.status && out_q.correction != CORR_NONE))
    else $error("gain write without a correction");

  a_run_ends_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_busy_q) |-> (out_valid_q && out_q.last))
    else $error("run drained without a last transaction");
`endif

endmodule
